/* hdl/sva_pkg.sv */
package sva_pkg;

    localparam int NUM_VOICES = 8;
    localparam int IDX_W      = $clog2(NUM_VOICES);
    localparam int CNT_W      = $clog2(NUM_VOICES + 1);

    // Attenuation of 0.85 in Q15, and the shift that turns velocity into volume.
    localparam logic [14:0] ATTEN_Q15 = 15'd27853;
    localparam int          VEL_SHIFT = 10;

    localparam logic [1:0] REG_HOLD_SAMPLES = 2'd0;
    localparam logic [1:0] REG_SUSTAIN_RATE = 2'd1;
    localparam logic [1:0] REG_FAST_RATE    = 2'd2;

    typedef enum logic [1:0] {
        FUNC_NOTE_ON,
        FUNC_NOTE_OFF,
        FUNC_VOICE_DONE,
        FUNC_UNUSED
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_PICK,
        ST_DONE
    } sva_state_t;

    typedef struct packed {
        logic [6:0]  note;
        logic [31:0] start;
        logic [16:0] volume;
        logic [23:0] hold;
        logic [15:0] release_rate;
    } voice_entry_t;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        voice_entry_t       data;
    } voice_wr_t;

endpackage

/* hdl/sva_voice_ram.sv */
module sva_voice_ram (
    input  logic                      aclk,
    input  sva_pkg::voice_wr_t        wr,
    input  logic                      rd_en,
    input  logic [sva_pkg::IDX_W-1:0] rd_addr,
    output sva_pkg::voice_entry_t     rd_data
);

    // Per-voice parameters; contents are undefined until a note-on loads them.
    sva_pkg::voice_entry_t mem [sva_pkg::NUM_VOICES];
    sva_pkg::voice_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/synth_voice_allocator_unit.sv */
// Polyphonic voice allocator with oldest-note stealing.
//
// Events arrive on the s_ channel (valid/ready); each accepted beat yields
// exactly one result beat on the m_ channel. Configuration registers are
// written through the cfg_ channel, which is always ready; write them only
// while the block is idle.
//
// A note-on or note-off walks the voice memory one entry per cycle: each
// entry is read, modified (volume attenuation, or release on a note match)
// and written back the cycle after. A note-on then writes the chosen voice.
// A note-off passes through the walk state and then the final state; a
// note-on through the walk, the pick and the final state; a voice-finished
// or unused event goes straight to the final state. The walk over the
// single-read-port memory dominates the time for a note event. The next
// event can be accepted once the result is registered, and one event is
// processed at a time.
//
// The result sits in an output register, so a new event is accepted while
// the previous result waits for m_ready. If the receiver stalls long enough
// that a new result is ready before the old one leaves, the block holds in
// its final state until the output register frees up.
// Reset (aresetn low, synchronous) marks every voice free and restores the
// configuration defaults; per-voice parameters are not cleared.
module synth_voice_allocator_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [6:0]  s_note,
    input  logic [6:0]  s_velocity,
    input  logic [2:0]  s_voice_sel,
    input  logic        s_sustain_pedal,
    input  logic [31:0] s_now,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_voice_index,
    output logic        m_stolen,
    output logic [7:0]  m_released_mask,
    output logic [15:0] m_release_rate
);

    localparam int NV = sva_pkg::NUM_VOICES;
    localparam int IW = sva_pkg::IDX_W;
    localparam int CW = sva_pkg::CNT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(NV - 1);

    // Configuration registers.
    logic [23:0] hold_samples_reg;
    logic [15:0] sustain_rate_reg;
    logic [15:0] fast_rate_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_samples_reg <= 24'd176400;
            sustain_rate_reg <= 16'd1;
            fast_rate_reg    <= 16'd16;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sva_pkg::REG_HOLD_SAMPLES: hold_samples_reg <= cfg_data;
                sva_pkg::REG_SUSTAIN_RATE: sustain_rate_reg <= cfg_data[15:0];
                sva_pkg::REG_FAST_RATE:    fast_rate_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Captured event.
    sva_pkg::func_t func_reg;
    logic [6:0]     note_reg;
    logic [6:0]     vel_reg;
    logic           pedal_reg;
    logic [31:0]    now_reg;

    sva_pkg::sva_state_t state_reg, state_next;

    logic           accept;
    sva_pkg::func_t s_func_t;
    assign s_ready  = (state_reg == sva_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign s_func_t = sva_pkg::func_t'(s_func);

    // Walk control: a read is issued for rd_cnt_reg, its data is handled in the
    // next cycle at p_idx_reg.
    logic [CW-1:0] rd_cnt_reg;
    logic          p_vld_reg;
    logic [IW-1:0] p_idx_reg;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          walk_last;

    assign rd_en     = (state_reg == sva_pkg::ST_WALK) && (rd_cnt_reg < CW'(NV));
    assign rd_addr   = rd_cnt_reg[IW-1:0];
    assign walk_last = p_vld_reg && (p_idx_reg == LAST_IDX);

    logic [NV-1:0] active_reg;

    // Search results gathered during the walk.
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;
    logic          old_found_reg;
    logic [IW-1:0] old_idx_reg;
    logic [31:0]   old_time_reg;
    logic [7:0]    mask_reg;
    logic [IW-1:0] pick_idx;
    logic          stolen_reg;
    logic [IW-1:0] chosen_reg;

    sva_pkg::voice_entry_t rd_data;
    sva_pkg::voice_wr_t    wr;

    sva_voice_ram u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic [15:0] off_rate;
    logic [31:0] atten_prod;
    logic        p_active;
    logic        note_hit;
    logic [5:0]  p_idx_ext;
    logic [5:0]  sel_ext;
    logic [5:0]  chosen_ext;

    assign off_rate   = pedal_reg ? sustain_rate_reg : fast_rate_reg;
    assign atten_prod = 32'(rd_data.volume) * 32'(sva_pkg::ATTEN_Q15);
    assign p_active   = active_reg[p_idx_reg];
    assign note_hit   = p_active && (rd_data.note == note_reg);
    assign p_idx_ext  = 6'(p_idx_reg);
    assign sel_ext    = {3'b000, s_voice_sel};
    assign chosen_ext = 6'(chosen_reg);
    assign pick_idx   = free_found_reg ? free_idx_reg : old_idx_reg;

    // Memory write: read-modify-write during the walk, full load on a pick.
    always_comb begin
        wr      = '0;
        wr.addr = p_idx_reg;
        wr.data = rd_data;
        if (state_reg == sva_pkg::ST_PICK) begin
            wr.en                = 1'b1;
            wr.addr              = pick_idx;
            wr.data.note         = note_reg;
            wr.data.start        = now_reg;
            wr.data.volume       = 17'(vel_reg) << sva_pkg::VEL_SHIFT;
            wr.data.hold         = hold_samples_reg;
            wr.data.release_rate = sustain_rate_reg;
        end else if (p_vld_reg) begin
            if (func_reg == sva_pkg::FUNC_NOTE_ON && p_active) begin
                wr.en          = 1'b1;
                wr.data.volume = atten_prod[31:15];
            end else if (func_reg == sva_pkg::FUNC_NOTE_OFF && note_hit) begin
                wr.en                = 1'b1;
                wr.data.hold         = '0;
                wr.data.release_rate = off_rate;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sva_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    logic out_free;
    assign out_free = !m_valid || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sva_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_func_t == sva_pkg::FUNC_NOTE_ON ||
                        s_func_t == sva_pkg::FUNC_NOTE_OFF) begin
                        state_next = sva_pkg::ST_WALK;
                    end else begin
                        state_next = sva_pkg::ST_DONE;
                    end
                end
            end
            sva_pkg::ST_WALK: begin
                if (walk_last) begin
                    state_next = (func_reg == sva_pkg::FUNC_NOTE_ON) ? sva_pkg::ST_PICK
                                                                     : sva_pkg::ST_DONE;
                end
            end
            sva_pkg::ST_PICK: begin
                state_next = sva_pkg::ST_DONE;
            end
            sva_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = sva_pkg::ST_IDLE;
                end
            end
            default: state_next = sva_pkg::ST_IDLE;
        endcase
    end

    // Event capture, walk counters and search.
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg  <= s_func_t;
            note_reg  <= s_note;
            vel_reg   <= s_velocity;
            pedal_reg <= s_sustain_pedal;
            now_reg   <= s_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_cnt_reg     <= '0;
            p_vld_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            old_found_reg  <= 1'b0;
            stolen_reg     <= 1'b0;
            chosen_reg     <= '0;
            mask_reg       <= '0;
        end else begin
            p_vld_reg <= rd_en;
            if (rd_en) begin
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
                p_idx_reg  <= rd_addr;
            end
            if (accept) begin
                rd_cnt_reg     <= '0;
                free_found_reg <= 1'b0;
                old_found_reg  <= 1'b0;
                stolen_reg     <= 1'b0;
                chosen_reg     <= '0;
                mask_reg       <= '0;
            end else if (p_vld_reg) begin
                if (!p_active) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= p_idx_reg;
                end else if (!old_found_reg || rd_data.start < old_time_reg) begin
                    old_found_reg <= 1'b1;
                    old_idx_reg   <= p_idx_reg;
                    old_time_reg  <= rd_data.start;
                end
                if (func_reg == sva_pkg::FUNC_NOTE_OFF && note_hit && p_idx_ext < 6'd8) begin
                    mask_reg[p_idx_ext[2:0]] <= 1'b1;
                end
            end else if (state_reg == sva_pkg::ST_PICK) begin
                chosen_reg <= pick_idx;
                stolen_reg <= !free_found_reg;
            end
        end
    end

    // Voice activity flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
        end else if (state_reg == sva_pkg::ST_PICK) begin
            active_reg[pick_idx] <= 1'b1;
        end else if (accept && s_func_t == sva_pkg::FUNC_VOICE_DONE
                     && sel_ext < 6'(NV)) begin
            active_reg[sel_ext[IW-1:0]] <= 1'b0;
        end
    end

    // Output register.
    logic        m_valid_reg;
    logic [2:0]  m_voice_index_reg;
    logic        m_stolen_reg;
    logic [7:0]  m_mask_reg;
    logic [15:0] m_rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == sva_pkg::ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == sva_pkg::ST_DONE && out_free) begin
            m_voice_index_reg <= 3'b000;
            m_stolen_reg      <= 1'b0;
            m_mask_reg        <= 8'h00;
            m_rate_reg        <= 16'h0000;
            case (func_reg)
                sva_pkg::FUNC_NOTE_ON: begin
                    m_voice_index_reg <= chosen_ext[2:0];
                    m_stolen_reg      <= stolen_reg;
                    m_rate_reg        <= sustain_rate_reg;
                end
                sva_pkg::FUNC_NOTE_OFF: begin
                    m_mask_reg <= mask_reg;
                    m_rate_reg <= off_rate;
                end
                default: ;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_voice_index   = m_voice_index_reg;
    assign m_stolen        = m_stolen_reg;
    assign m_released_mask = m_mask_reg;
    assign m_release_rate  = m_rate_reg;

    // The write-back of one entry never lands on the entry being read.
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.en && rd_en) |-> (wr.addr != rd_addr))
        else $error("memory write and read hit the same voice");

    // Stealing only happens when every voice is busy.
    a_steal_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sva_pkg::ST_PICK && !free_found_reg) |-> (&active_reg))
        else $error("voice stolen while a free voice exists");

    // A picked voice is active afterwards.
    a_pick_activates: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sva_pkg::ST_PICK) |=> active_reg[$past(pick_idx)])
        else $error("picked voice not marked active");

    // A stalled result keeps the sequencer waiting in its final state.
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sva_pkg::ST_DONE && m_valid && !m_ready) |=>
        (state_reg == sva_pkg::ST_DONE))
        else $error("result overwritten while stalled");

    // A release mask never comes with a note-on voice choice.
    a_mask_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_released_mask != 8'h00) |-> (!m_stolen && m_voice_index == 3'b000))
        else $error("release mask on a note-on result");

endmodule
